@@ src/pcd_pkg.sv @@
// ----------------------------------------------------------------------------
// pcd_pkg
// shared types, constants and the crc-32 byte update for the chunk deframer
// ----------------------------------------------------------------------------
package pcd_pkg;

   localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
   localparam logic [31:0] CRC_PRESET = 32'hFFFFFFFF;
   localparam logic [1:0]  FIELD_LAST = 2'd3;

   typedef enum logic [1:0] {
      PH_LENGTH = 2'd0,
      PH_TYPE   = 2'd1,
      PH_DATA   = 2'd2,
      PH_CRC    = 2'd3
   } phase_type;

   // reflected crc-32, one byte, lsb first
   function automatic logic [31:0] crc_update(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

@@ src/pcd_req_if.sv @@
// ----------------------------------------------------------------------------
// pcd_req_if
// request channel: one raw byte of the chunk stream per request
// ----------------------------------------------------------------------------
interface pcd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

@@ src/pcd_rsp_if.sv @@
// ----------------------------------------------------------------------------
// pcd_rsp_if
// response channel: echoed byte with its role and the chunk status
// ----------------------------------------------------------------------------
interface pcd_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  byte_value;
   logic [1:0]  byte_role;
   logic        chunk_end;
   logic        crc_ok;
   logic [31:0] chunk_length;
   logic [31:0] chunk_tag;

   modport source (output valid, output byte_value, output byte_role, output chunk_end,
                   output crc_ok, output chunk_length, output chunk_tag, input ready);
   modport sink   (input valid, input byte_value, input byte_role, input chunk_end,
                   input crc_ok, input chunk_length, input chunk_tag, output ready);
endinterface

@@ src/png_chunk_deframer_crc_check.sv @@
// response: registered, valid in the cycle after its request is accepted
// throughput: one byte per cycle while rsp.ready keeps up; the crc byte update and
// the phase counter settle within the single pass between the chunk state and the
// response register; reset: synchronous, active high; phase returns to length, crc
// preset to all ones, no response pending; no clearing pass
// ----------------------------------------------------------------------------
// png_chunk_deframer_crc_check
// splits a chunk byte stream into length, type, data and crc and checks crc-32
// ----------------------------------------------------------------------------
module png_chunk_deframer_crc_check (
   input  logic  clock,
   input  logic  reset,
   pcd_req_if.sink   req,
   pcd_rsp_if.source rsp
);

   pcd_pkg::phase_type phase_ff, phase_in;
   logic [31:0] cnt_ff, cnt_in;
   logic [31:0] len_ff, len_in;
   logic [31:0] type_ff, type_in;
   logic [31:0] crc_ff, crc_in;
   logic [31:0] rcv_ff, rcv_in;

   logic        req_fire;
   logic        field_last;
   logic        data_last;
   logic        end_in;
   logic        ok_in;

   logic        out_valid_ff;
   logic [7:0]  out_byte_ff;
   logic [1:0]  out_role_ff;
   logic        out_end_ff;
   logic        out_ok_ff;
   logic [31:0] out_len_ff;
   logic [31:0] out_type_ff;

   assign req.ready  = !out_valid_ff || rsp.ready;
   assign req_fire   = req.valid && req.ready;
   assign field_last = (cnt_ff[1:0] == pcd_pkg::FIELD_LAST);
   assign data_last  = (cnt_ff == (len_ff - 32'd1));

   // next phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         pcd_pkg::PH_LENGTH: begin
            if (field_last) phase_in = pcd_pkg::PH_TYPE;
         end
         pcd_pkg::PH_TYPE: begin
            if (field_last) phase_in = (len_ff == 32'd0) ? pcd_pkg::PH_CRC : pcd_pkg::PH_DATA;
         end
         pcd_pkg::PH_DATA: begin
            if (data_last) phase_in = pcd_pkg::PH_CRC;
         end
         pcd_pkg::PH_CRC: begin
            if (field_last) phase_in = pcd_pkg::PH_LENGTH;
         end
         default: phase_in = pcd_pkg::PH_LENGTH;
      endcase
   end

   // datapath and response fields
   always_comb begin
      cnt_in  = cnt_ff + 32'd1;
      len_in  = len_ff;
      type_in = type_ff;
      crc_in  = crc_ff;
      rcv_in  = rcv_ff;
      end_in  = 1'b0;
      ok_in   = 1'b0;
      case (phase_ff)
         pcd_pkg::PH_LENGTH: begin
            if (cnt_ff == 32'd0) begin
               len_in  = {24'd0, req.data_byte};
               type_in = 32'd0;
               rcv_in  = 32'd0;
            end else begin
               len_in = {len_ff[23:0], req.data_byte};
            end
            if (field_last) cnt_in = 32'd0;
         end
         pcd_pkg::PH_TYPE: begin
            type_in = {type_ff[23:0], req.data_byte};
            crc_in  = pcd_pkg::crc_update(crc_ff, req.data_byte);
            if (field_last) cnt_in = 32'd0;
         end
         pcd_pkg::PH_DATA: begin
            crc_in = pcd_pkg::crc_update(crc_ff, req.data_byte);
            if (data_last) cnt_in = 32'd0;
         end
         pcd_pkg::PH_CRC: begin
            rcv_in = {rcv_ff[23:0], req.data_byte};
            if (field_last) begin
               end_in = 1'b1;
               ok_in  = (rcv_in == ~crc_ff);
               crc_in = pcd_pkg::CRC_PRESET;
               cnt_in = 32'd0;
            end
         end
         default: cnt_in = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= pcd_pkg::PH_LENGTH;
         cnt_ff   <= 32'd0;
         len_ff   <= 32'd0;
         type_ff  <= 32'd0;
         crc_ff   <= pcd_pkg::CRC_PRESET;
         rcv_ff   <= 32'd0;
      end else if (req_fire) begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         len_ff   <= len_in;
         type_ff  <= type_in;
         crc_ff   <= crc_in;
         rcv_ff   <= rcv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (req_fire) begin
         out_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         out_byte_ff <= req.data_byte;
         out_role_ff <= phase_ff;
         out_end_ff  <= end_in;
         out_ok_ff   <= ok_in;
         out_len_ff  <= len_in;
         out_type_ff <= type_in;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.byte_value   = out_byte_ff;
   assign rsp.byte_role    = out_role_ff;
   assign rsp.chunk_end    = out_end_ff;
   assign rsp.crc_ok       = out_ok_ff;
   assign rsp.chunk_length = out_len_ff;
   assign rsp.chunk_tag    = out_type_ff;

endmodule
